FILE: hdl/assert_macros.svh
// Assertion helpers for the supply source detector.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define SSHD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sshd assertion failed");

// The condition must never be true outside reset.
`define SSHD_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sshd forbidden condition seen");

`else

`define SSHD_ASSERT(label, clk, rst_n, prop)
`define SSHD_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: hdl/sshd_pkg.sv
package sshd_pkg;

    // Field widths.
    localparam int SAMPLE_W  = 16;
    localparam int TIME_W    = 32;
    localparam int THR_W     = 14;
    localparam int VOTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Decision tuning.
    localparam logic [VOTE_W-1:0] SWITCH_VOTES   = 8'd3;
    localparam logic [VOTE_W-1:0] VOTE_MAX       = 8'd255;
    localparam logic [TIME_W-1:0] SETTLE_TIME_MS = 32'd60000;

    // Threshold limits and reset values.
    localparam logic [THR_W-1:0] THR_MIN_MV      = 14'd1000;
    localparam logic [THR_W-1:0] THR_MAX_MV      = 14'd12000;
    localparam logic [THR_W-1:0] MAINS_HI_RESET  = 14'd4500;
    localparam logic [THR_W-1:0] MAINS_LO_RESET  = 14'd4300;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAINS_HI = 2'd0,
        CFG_MAINS_LO = 2'd1
    } t_cfg_idx;

    // One configuration write request.
    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] index;
        logic [THR_W-1:0]     value;
    } t_cfg_wr;

    // One result item.
    typedef struct packed {
        logic on_mains;
        logic on_battery;
        logic switched;
    } t_result;

    // Decision state as seen from outside the core.
    typedef struct packed {
        logic              mains_state;
        logic [VOTE_W-1:0] votes;
        logic [THR_W-1:0]  hi_mv;
        logic [THR_W-1:0]  lo_mv;
    } t_status;

endpackage

FILE: hdl/sshd_ifs.sv
// Sample request channel.
interface sshd_sample_if;
    import sshd_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_mv;
    logic [TIME_W-1:0]   time_ms;

    modport source (output valid, output sample_mv, output time_ms, input ready);
    modport sink (input valid, input sample_mv, input time_ms, output ready);
endinterface

// Decision result channel.
interface sshd_result_if;
    logic valid;
    logic ready;
    logic on_mains;
    logic on_battery;
    logic switched;

    modport source (output valid, output on_mains, output on_battery, output switched,
                    input ready);
    modport sink (input valid, input on_mains, input on_battery, input switched,
                  output ready);
endinterface

// Configuration write channel.
interface sshd_cfg_if;
    import sshd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THR_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/sshd_core.sv
module sshd_core
    import sshd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg_wr             i_cfg,
    input  logic                i_step,
    input  logic [SAMPLE_W-1:0] i_sample_mv,
    input  logic [TIME_W-1:0]   i_time_ms,
    output t_result             o_res,
    output t_status             o_status
);

    logic              r_seeded, n_seeded;
    logic              r_mains, n_mains;
    logic [VOTE_W-1:0] r_votes, n_votes;
    logic [TIME_W-1:0] r_last, n_last;
    logic [THR_W-1:0]  r_hi, n_hi;
    logic [THR_W-1:0]  r_lo, n_lo;

    logic [SAMPLE_W:0] sample_x2;
    logic [SAMPLE_W:0] thr_sum;
    logic              seed_mains;
    logic              vote_mains;
    logic              vote_battery;
    logic              voting;
    logic              vote_for_mains;
    logic [TIME_W-1:0] elapsed;
    logic [VOTE_W-1:0] votes_inc;
    logic              flip;
    logic              cfg_in_range;
    logic              cfg_hi_ok;
    logic              cfg_lo_ok;

    // Seeding compare: twice the sample against the sum of both thresholds.
    assign sample_x2  = {i_sample_mv, 1'b0};
    assign thr_sum    = {{(SAMPLE_W + 1 - THR_W){1'b0}}, r_hi}
                      + {{(SAMPLE_W + 1 - THR_W){1'b0}}, r_lo};
    assign seed_mains = (sample_x2 >= thr_sum);

    // Votes from the two thresholds; between them there is no vote.
    assign vote_mains     = (i_sample_mv >= {{(SAMPLE_W - THR_W){1'b0}}, r_hi});
    assign vote_battery   = (i_sample_mv <= {{(SAMPLE_W - THR_W){1'b0}}, r_lo});
    assign voting         = vote_mains || vote_battery;
    assign vote_for_mains = vote_mains;

    // Wrapping elapsed time and the saturating vote count.
    assign elapsed   = i_time_ms - r_last;
    assign votes_inc = (r_votes < VOTE_MAX) ? r_votes + 1'b1 : r_votes;
    assign flip      = r_seeded && voting && (vote_for_mains != r_mains)
                    && (elapsed >= SETTLE_TIME_MS) && (votes_inc >= SWITCH_VOTES);

    // Threshold write checks.
    assign cfg_in_range = (i_cfg.value >= THR_MIN_MV) && (i_cfg.value <= THR_MAX_MV);
    assign cfg_hi_ok    = cfg_in_range && (i_cfg.value > r_lo);
    assign cfg_lo_ok    = cfg_in_range && (i_cfg.value < r_hi);

    // Next decision state.
    always_comb begin
        n_seeded = r_seeded;
        n_mains  = r_mains;
        n_votes  = r_votes;
        n_last   = r_last;
        n_hi     = r_hi;
        n_lo     = r_lo;
        if (i_step) begin
            if (!r_seeded) begin
                n_seeded = 1'b1;
                n_mains  = seed_mains;
                n_votes  = '0;
                n_last   = i_time_ms;
            end else if (!voting || (vote_for_mains == r_mains)) begin
                n_votes = '0;
            end else if (elapsed < SETTLE_TIME_MS) begin
                n_votes = '0;
            end else if (flip) begin
                n_mains = vote_for_mains;
                n_votes = '0;
                n_last  = i_time_ms;
            end else begin
                n_votes = votes_inc;
            end
        end
        if (i_cfg.en) begin
            unique case (i_cfg.index)
                CFG_MAINS_HI: begin
                    if (cfg_hi_ok) begin
                        n_hi    = i_cfg.value;
                        n_votes = '0;
                    end
                end
                CFG_MAINS_LO: begin
                    if (cfg_lo_ok) begin
                        n_lo    = i_cfg.value;
                        n_votes = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_mains  <= 1'b0;
            r_votes  <= '0;
            r_last   <= '0;
            r_hi     <= MAINS_HI_RESET;
            r_lo     <= MAINS_LO_RESET;
        end else begin
            r_seeded <= n_seeded;
            r_mains  <= n_mains;
            r_votes  <= n_votes;
            r_last   <= n_last;
            r_hi     <= n_hi;
            r_lo     <= n_lo;
        end
    end

    // Result of the item being stepped.
    assign o_res.on_mains   = n_mains;
    assign o_res.on_battery = !n_mains;
    assign o_res.switched   = i_step && flip;

    assign o_status.mains_state = r_mains;
    assign o_status.votes       = r_votes;
    assign o_status.hi_mv       = r_hi;
    assign o_status.lo_mv       = r_lo;

endmodule

FILE: hdl/supply_source_hysteresis_detector_top.sv
// Channel    Direction  Payload
// i_sample   in         sample_mv[15:0], time_ms[31:0]
// o_result   out        on_mains, on_battery, switched
// i_cfg      in         index[1:0], data[13:0] (0: mains_hi_mv, 1: mains_lo_mv)
//
// A sample request is held in the input register and is decided on the way into
// the result register, which presents its result.
// One sample is taken every cycle unless the result side stalls.
// Reset is synchronous and active low; thresholds return to 4500 and 4300 mV.
// A stalled result holds the result register, then the input register, then i_sample.
// Configuration writes are always taken.
`include "assert_macros.svh"

module supply_source_hysteresis_detector_top
    import sshd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sshd_sample_if.sink   i_sample,
    sshd_result_if.source o_result,
    sshd_cfg_if.sink      i_cfg
);

    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [TIME_W-1:0]   r_s1_time;
    logic                r_out_valid;
    t_result             r_out;

    logic    out_free;
    logic    s1_move;
    logic    s1_load;
    t_cfg_wr cfg_wr;
    t_result core_res;
    t_status core_status;

    // Handshake flow through the two register stages.
    assign out_free = !r_out_valid || o_result.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign s1_load  = i_sample.valid && i_sample.ready;
    assign i_sample.ready = !r_s1_valid || out_free;

    // Configuration writes go straight to the core.
    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.en    = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.value = i_cfg.data;

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_sample <= i_sample.sample_mv;
            r_s1_time   <= i_sample.time_ms;
        end
    end

    sshd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_step      (s1_move),
        .i_sample_mv (r_s1_sample),
        .i_time_ms   (r_s1_time),
        .o_res       (core_res),
        .o_status    (core_status)
    );

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= core_res;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.on_mains   = r_out.on_mains;
    assign o_result.on_battery = r_out.on_battery;
    assign o_result.switched   = r_out.switched;

    // Thresholds always stay ordered, whatever is written.
    `SSHD_ASSERT(a_thr_order, i_clk, i_rst_n, core_status.hi_mv > core_status.lo_mv)

    // The vote counter clears before it reaches the switch count.
    `SSHD_ASSERT(a_votes_bound, i_clk, i_rst_n, core_status.votes < SWITCH_VOTES)

    // A switching sample leaves the state at the new decision with no votes.
    `SSHD_ASSERT(a_switch_state, i_clk, i_rst_n,
        s1_move && core_res.switched |=> (core_status.votes == '0)
            && (core_status.mains_state == $past(core_res.on_mains)))

    // A pending sample is never dropped while the result side stalls.
    `SSHD_ASSERT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !out_free |=> r_s1_valid)

endmodule
